>>> sv/lsbc_pkg.sv
// ----------------------------------------------------------------------------
// lsbc_pkg
// Types and constants for the status and activity LED blink controller.
// ----------------------------------------------------------------------------
package lsbc_pkg;

    localparam int TimeWidth  = 32;
    localparam int PeriodWidth = 16;
    localparam int BlinkWidth = 4;
    localparam int CfgIdxWidth = 3;

    typedef logic [TimeWidth-1:0]   time_t;
    typedef logic [PeriodWidth-1:0] period_t;
    typedef logic [BlinkWidth-1:0]  blink_cnt_t;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_SET_MODE = 3'd1,
        ACT_RX_FLASH = 3'd2,
        ACT_TX_FLASH = 3'd3,
        ACT_CMD_FLASH = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        MODE_OFF   = 3'd0,
        MODE_ON    = 3'd1,
        MODE_SLOW  = 3'd2,
        MODE_FAST  = 3'd3,
        MODE_ERROR = 3'd4
    } mode_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_SLOW_HALF_PERIOD   = 3'd0,
        REG_FAST_HALF_PERIOD   = 3'd1,
        REG_ERROR_PAUSE        = 3'd2,
        REG_ERROR_BLINKS       = 3'd3,
        REG_SHORT_FLASH_LENGTH = 3'd4,
        REG_LONG_FLASH_LENGTH  = 3'd5
    } cfg_reg_t;

    localparam period_t    SlowHalfPeriodRst   = 16'd500;
    localparam period_t    FastHalfPeriodRst   = 16'd100;
    localparam period_t    ErrorPauseRst       = 16'd1000;
    localparam blink_cnt_t ErrorBlinksRst      = 4'd6;
    localparam period_t    ShortFlashLengthRst = 16'd50;
    localparam period_t    LongFlashLengthRst  = 16'd100;

endpackage

>>> sv/led_status_blink_controller.sv
// ----------------------------------------------------------------------------
// led_status_blink_controller
// Status and activity LED driver fed by timestamped event transfers.
// ----------------------------------------------------------------------------
// One transfer in, one transfer out: each accepted item (tick, set mode or
// flash) produces the LED levels after that item. An item is captured in an
// input register, its effect on the mode, toggle timer, error burst counter
// and flash deadline is worked out from that register and written to the
// state and the result register together, so a new item is taken every
// cycle while the output is not stalled. Time compares use signed 32-bit
// differences, so timestamps may wrap. Configuration registers take effect
// from the next item.
module led_status_blink_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          action,
    input  lsbc_pkg::time_t                     now,
    input  logic [2:0]                          mode,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                status_led,
    output logic                                activity_led,
    input  logic                                cfg_write,
    input  logic [lsbc_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  lsbc_pkg::period_t                   cfg_data
);
    import lsbc_pkg::*;

    // configuration
    period_t    slow_half_reg;
    period_t    fast_half_reg;
    period_t    error_pause_reg;
    blink_cnt_t error_blinks_reg;
    period_t    short_flash_reg;
    period_t    long_flash_reg;

    // input stage
    logic       s1_valid_reg;
    logic [2:0] s1_action_reg;
    time_t      s1_now_reg;
    logic [2:0] s1_mode_reg;

    // block state
    mode_t      mode_reg;
    mode_t      mode_next;
    logic       status_level_reg;
    logic       status_level_next;
    time_t      last_toggle_reg;
    time_t      last_toggle_next;
    blink_cnt_t blink_cnt_reg;
    blink_cnt_t blink_cnt_next;
    logic       flash_active_reg;
    logic       flash_active_next;
    time_t      flash_deadline_reg;
    time_t      flash_deadline_next;

    // result register
    logic       out_valid_reg;
    logic       status_led_reg;
    logic       activity_led_reg;

    logic       s1_fire;
    logic       in_fire;
    time_t      toggle_diff;
    time_t      flash_diff;
    period_t    half_period;
    logic       toggle_due;
    blink_cnt_t blink_cnt_inc;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_fire  = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign status_led   = status_led_reg;
    assign activity_led = activity_led_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_half_reg    <= SlowHalfPeriodRst;
            fast_half_reg    <= FastHalfPeriodRst;
            error_pause_reg  <= ErrorPauseRst;
            error_blinks_reg <= ErrorBlinksRst;
            short_flash_reg  <= ShortFlashLengthRst;
            long_flash_reg   <= LongFlashLengthRst;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SLOW_HALF_PERIOD:   slow_half_reg    <= cfg_data;
                REG_FAST_HALF_PERIOD:   fast_half_reg    <= cfg_data;
                REG_ERROR_PAUSE:        error_pause_reg  <= cfg_data;
                REG_ERROR_BLINKS:       error_blinks_reg <= cfg_data[BlinkWidth-1:0];
                REG_SHORT_FLASH_LENGTH: short_flash_reg  <= cfg_data;
                REG_LONG_FLASH_LENGTH:  long_flash_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_action_reg <= action;
            s1_now_reg    <= now;
            s1_mode_reg   <= mode;
        end
    end

    // item evaluation
    assign toggle_diff   = s1_now_reg - last_toggle_reg;
    assign flash_diff    = s1_now_reg - flash_deadline_reg;
    assign half_period   = (mode_reg == MODE_SLOW) ? slow_half_reg : fast_half_reg;
    assign toggle_due    = !toggle_diff[TimeWidth-1]
                           && (toggle_diff >= {{(TimeWidth-PeriodWidth){1'b0}}, half_period});
    assign blink_cnt_inc = blink_cnt_reg + 1'b1;

    always_comb
    begin
        mode_next           = mode_reg;
        status_level_next   = status_level_reg;
        last_toggle_next    = last_toggle_reg;
        blink_cnt_next      = blink_cnt_reg;
        flash_active_next   = flash_active_reg;
        flash_deadline_next = flash_deadline_reg;
        case (s1_action_reg)
            ACT_TICK:
            begin
                if ((mode_reg inside {MODE_SLOW, MODE_FAST, MODE_ERROR}) && toggle_due)
                begin
                    status_level_next = !status_level_reg;
                    last_toggle_next  = s1_now_reg;
                    // a toggle to unlit ends one error blink
                    if (mode_reg == MODE_ERROR && status_level_reg)
                    begin
                        blink_cnt_next = blink_cnt_inc;
                        if (blink_cnt_inc >= error_blinks_reg)
                        begin
                            blink_cnt_next   = '0;
                            last_toggle_next = s1_now_reg
                                + {{(TimeWidth-PeriodWidth){1'b0}}, error_pause_reg};
                        end
                    end
                end
                if (flash_active_reg && !flash_diff[TimeWidth-1])
                begin
                    flash_active_next = 1'b0;
                end
            end
            ACT_SET_MODE:
            begin
                if (s1_mode_reg inside {[MODE_OFF:MODE_ERROR]})
                begin
                    mode_next         = mode_t'(s1_mode_reg);
                    status_level_next = (s1_mode_reg != MODE_OFF);
                    last_toggle_next  = s1_now_reg;
                    blink_cnt_next    = '0;
                end
            end
            ACT_RX_FLASH, ACT_TX_FLASH:
            begin
                flash_active_next   = 1'b1;
                flash_deadline_next = s1_now_reg
                    + {{(TimeWidth-PeriodWidth){1'b0}}, short_flash_reg};
            end
            ACT_CMD_FLASH:
            begin
                flash_active_next   = 1'b1;
                flash_deadline_next = s1_now_reg
                    + {{(TimeWidth-PeriodWidth){1'b0}}, long_flash_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_OFF;
            status_level_reg   <= 1'b0;
            last_toggle_reg    <= '0;
            blink_cnt_reg      <= '0;
            flash_active_reg   <= 1'b0;
            flash_deadline_reg <= '0;
        end
        else if (s1_fire)
        begin
            mode_reg           <= mode_next;
            status_level_reg   <= status_level_next;
            last_toggle_reg    <= last_toggle_next;
            blink_cnt_reg      <= blink_cnt_next;
            flash_active_reg   <= flash_active_next;
            flash_deadline_reg <= flash_deadline_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            status_led_reg   <= status_level_next;
            activity_led_reg <= flash_active_next;
        end
    end

`ifndef SYNTH
    // a processed item always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("processed item did not reach the result register");

    // a held result always matches the block state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_led_reg == status_level_reg)
                          && (activity_led_reg == flash_active_reg))
        else $error("result register out of step with led state");

    // setting off mode darkens the status led
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_action_reg == ACT_SET_MODE) && (s1_mode_reg == MODE_OFF)
        |=> !status_level_reg && (mode_reg == MODE_OFF))
        else $error("off mode left status led lit");

    // any flash lights the activity led
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && ((s1_action_reg == ACT_RX_FLASH) || (s1_action_reg == ACT_TX_FLASH)
                    || (s1_action_reg == ACT_CMD_FLASH))
        |=> flash_active_reg)
        else $error("flash did not light activity led");

    // input side only backs up when the input stage holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a held item");
`endif

endmodule
